[src/wgns_pkg.sv]
// shared types and constants of the walkability grid search block
`timescale 1ns / 1ps
`default_nettype none
package wgns_pkg;

  // working width of signed tile coordinates: origin plus search offset
  localparam int CW = 11;

  localparam logic [7:0] OPEN_CODE = 8'd34;
  localparam logic [7:0] NONE_COORD = 8'hFF;

  typedef enum logic [2:0] {
    KIND_LOAD    = 3'd0,
    KIND_BLOCK   = 3'd1,
    KIND_OPEN    = 3'd2,
    KIND_QUERY   = 3'd3,
    KIND_NEAREST = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    REG_WIDTH   = 2'd0,
    REG_HEIGHT  = 2'd1,
    REG_BLOCKED = 2'd2,
    REG_RADIUS  = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SEARCH,
    ST_DRAIN,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic       walk;
    logic       found;
    logic [7:0] fx;
    logic [7:0] fy;
  } res_t;

endpackage
`default_nettype wire

[src/wgns_tile_mem.sv]
// single-port-write, single-port-read tile byte store with registered read data
`timescale 1ns / 1ps
`default_nettype none
module wgns_tile_mem #(
  parameter int DEPTH = 16384,
  parameter int AW    = 14
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [7:0]    wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [7:0]    rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[src/walkability_grid_nearest_search.sv]
// top level: walkability tile grid with query and nearest walkable tile search
`timescale 1ns / 1ps
`default_nettype none
// Holds one byte per tile in a MAX_WIDTH x MAX_HEIGHT store (tile x,y at y*MAX_WIDTH+x) and
// answers one result word per input word. Load, mark and unused kinds go from acceptance
// straight to the result state; a walkability query passes through the check state first.
// A nearest search probes one tile per cycle through the single read port of the tile
// store, scanning squares of radius 1 up to min(radius_limit, MAX_RADIUS)-1, offsets x
// outer and y inner; it issues at most sum over r of (2r)^2 probes. The block takes no
// new word while one is being worked on, but does take one while a result waits on the
// output. The store has no reset; reading a tile never written gives an undefined answer.
module walkability_grid_nearest_search import wgns_pkg::*; #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128,
  parameter int MAX_RADIUS = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [1:0]        cfg_idx_i,
  input  wire logic [7:0]        cfg_wdata_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [2:0]        kind_i,
  input  wire logic signed [8:0] tile_x_i,
  input  wire logic signed [8:0] tile_y_i,
  input  wire logic [7:0]        tile_value_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic                   is_walkable_o,
  output logic                   found_o,
  output logic signed [7:0]      found_x_o,
  output logic signed [7:0]      found_y_o
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int RW    = $clog2(MAX_RADIUS + 1);
  localparam int DW    = RW + 1;

  function automatic logic in_bounds(input logic signed [CW-1:0] x,
                                     input logic signed [CW-1:0] y,
                                     input logic signed [CW-1:0] w,
                                     input logic signed [CW-1:0] h);
    return !x[CW-1] && !y[CW-1] && (x < w) && (y < h);
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic signed [CW-1:0] x,
                                            input logic signed [CW-1:0] y);
    return AW'(AW'(y[YW-1:0]) * AW'(MAX_WIDTH)) + AW'(x[XW-1:0]);
  endfunction

  // configuration
  logic [7:0] width_q, height_q, blocked_q;
  logic [6:0] radius_q;

  // sequencer
  state_e state_q, state_d;
  res_t   res_q, res_d;
  logic   out_valid_q, out_valid_d;
  res_t   out_q;
  logic   load_out;

  logic signed [CW-1:0] ox_q, ox_d, oy_q, oy_d;
  logic                 inb_q, inb_d;
  logic [RW-1:0]        r_q, r_d, lim_q, lim_d;
  logic signed [DW-1:0] dx_q, dx_d, dy_q, dy_d;
  logic                 pv_q, pv_d;
  logic signed [CW-1:0] pxq_q, pxq_d, pyq_q, pyq_d;

  logic signed [CW-1:0] w_eff, h_eff, ix, iy, px, py;
  logic                 in_fire, inb_in, tile_ok, hit;
  logic [RW-1:0]        lim_in;
  logic signed [DW-1:0] r_s, r_m1;
  logic                 dy_end, dx_end, r_last;

  logic          mem_we;
  logic [7:0]    mem_wdata, mem_rdata;
  logic [AW-1:0] mem_raddr;

  assign w_eff = (int'(width_q) < MAX_WIDTH) ? CW'(width_q) : CW'(MAX_WIDTH);
  assign h_eff = (int'(height_q) < MAX_HEIGHT) ? CW'(height_q) : CW'(MAX_HEIGHT);
  assign lim_in = (int'(radius_q) < MAX_RADIUS) ? RW'(radius_q) : RW'(MAX_RADIUS);

  assign ix = CW'(tile_x_i);
  assign iy = CW'(tile_y_i);
  assign inb_in = in_bounds(ix, iy, w_eff, h_eff);

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  // probe coordinate: the one shared adder pair of the search
  assign px = ox_q + CW'(dx_q);
  assign py = oy_q + CW'(dy_q);

  assign r_s    = DW'(r_q);
  assign r_m1   = r_s - DW'(1);
  assign dy_end = (dy_q == r_m1);
  assign dx_end = (dx_q == r_m1);
  assign r_last = ({1'b0, r_q} + (RW + 1)'(1)) == {1'b0, lim_q};

  assign tile_ok = (mem_rdata != blocked_q) && (mem_rdata != 8'd0);
  assign hit     = pv_q && tile_ok;

  // tile store port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = tile_value_i;
    case (kind_e'(kind_i))
      KIND_BLOCK: mem_wdata = blocked_q;
      KIND_OPEN:  mem_wdata = OPEN_CODE;
      default:    mem_wdata = tile_value_i;
    endcase
    if (in_fire && inb_in && (kind_i <= KIND_OPEN)) begin
      mem_we = 1'b1;
    end
    mem_raddr = (state_q == ST_IDLE) ? addr_of(ix, iy) : addr_of(px, py);
  end

  wgns_tile_mem #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_tile_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(addr_of(ix, iy)),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  always_comb begin
    state_d  = state_q;
    res_d    = res_q;
    ox_d     = ox_q;
    oy_d     = oy_q;
    inb_d    = inb_q;
    r_d      = r_q;
    lim_d    = lim_q;
    dx_d     = dx_q;
    dy_d     = dy_q;
    pv_d     = 1'b0;
    pxq_d    = px;
    pyq_d    = py;
    load_out = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          res_d = '{walk: 1'b0, found: 1'b0, fx: NONE_COORD, fy: NONE_COORD};
          ox_d  = ix;
          oy_d  = iy;
          inb_d = inb_in;
          unique case (kind_e'(kind_i))
            KIND_QUERY: state_d = ST_CHECK;
            KIND_NEAREST: begin
              r_d   = RW'(1);
              lim_d = lim_in;
              dx_d  = -DW'(1);
              dy_d  = -DW'(1);
              state_d = (lim_in > RW'(1)) ? ST_SEARCH : ST_RESULT;
            end
            default: state_d = ST_RESULT;
          endcase
        end
      end
      ST_CHECK: begin
        res_d.walk = inb_q && tile_ok;
        state_d    = ST_RESULT;
      end
      ST_SEARCH: begin
        pv_d = in_bounds(px, py, w_eff, h_eff);
        if (hit) begin
          // the probe of the last cycle wins over the one issued now
          res_d.found = 1'b1;
          res_d.fx    = pxq_q[7:0];
          res_d.fy    = pyq_q[7:0];
          state_d     = ST_RESULT;
        end else if (!dy_end) begin
          dy_d = dy_q + DW'(1);
        end else if (!dx_end) begin
          dx_d = dx_q + DW'(1);
          dy_d = -r_s;
        end else if (!r_last) begin
          r_d  = r_q + RW'(1);
          dx_d = -(r_s + DW'(1));
          dy_d = -(r_s + DW'(1));
        end else begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (hit) begin
          res_d.found = 1'b1;
          res_d.fx    = pxq_q[7:0];
          res_d.fy    = pyq_q[7:0];
        end
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = load_out || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      pv_q        <= 1'b0;
      width_q     <= 8'd128;
      height_q    <= 8'd128;
      blocked_q   <= 8'd255;
      radius_q    <= 7'd10;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      pv_q        <= pv_d;
      if (cfg_we_i) begin
        unique case (reg_idx_e'(cfg_idx_i))
          REG_WIDTH:   width_q   <= cfg_wdata_i;
          REG_HEIGHT:  height_q  <= cfg_wdata_i;
          REG_BLOCKED: blocked_q <= cfg_wdata_i;
          REG_RADIUS:  radius_q  <= cfg_wdata_i[6:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    ox_q  <= ox_d;
    oy_q  <= oy_d;
    inb_q <= inb_d;
    r_q   <= r_d;
    lim_q <= lim_d;
    dx_q  <= dx_d;
    dy_q  <= dy_d;
    pxq_q <= pxq_d;
    pyq_q <= pyq_d;
    if (load_out) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign is_walkable_o = out_q.walk;
  assign found_o       = out_q.found;
  assign found_x_o     = out_q.fx;
  assign found_y_o     = out_q.fy;

endmodule
`default_nettype wire

[src/wgns_checker.sv]
// port-level checks of the walkability grid search block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module wgns_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_ready_o,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire logic              is_walkable_o,
  input wire logic              found_o,
  input wire logic signed [7:0] found_x_o,
  input wire logic signed [7:0] found_y_o
);

  // a stalled result stays valid and keeps its coordinates
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(found_x_o) && $stable(found_y_o))
    else $error("result word changed while stalled");

  // the block is not ready in the cycle after it accepts a word
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken on back-to-back cycles");

  // no hit means both coordinates read minus one
  a_none_coords: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> found_x_o == 8'hFF && found_y_o == 8'hFF)
    else $error("coordinates given without a hit");

  // a query answer and a search hit never share one word
  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(is_walkable_o && found_o))
    else $error("query and search flags both set");

endmodule

bind walkability_grid_nearest_search wgns_checker u_wgns_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .is_walkable_o(is_walkable_o),
  .found_o      (found_o),
  .found_x_o    (found_x_o),
  .found_y_o    (found_y_o)
);
`default_nettype wire
